@@ design/met_pkg.sv @@
`timescale 1ns / 1ps
// Package for the escape-time unit: payload structs, field widths, class codes.
// No dependencies; imported by mandelbrot_escape_time_unit.
package met_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int LIMIT_WIDTH = 16;

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'd5000;

  localparam logic [1:0] CLS_MARKER  = 2'd0;
  localparam logic [1:0] CLS_ESCAPED = 2'd1;
  localparam logic [1:0] CLS_INSIDE  = 2'd2;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] c_real;
    logic signed [COORD_WIDTH-1:0] c_imag;
  } met_in_t;

  typedef struct packed {
    logic [1:0]             point_class;
    logic [COUNT_WIDTH-1:0] escape_count;
  } met_out_t;

endpackage

@@ design/mandelbrot_escape_time_unit.sv @@
`timescale 1ns / 1ps
// Escape-time classifier for one complex point: marker, bulb and cardioid tests,
// then z = z^2 + c on a shared sequenced multiplier. Depends on met_pkg.
//
// One point at a time. All arithmetic is 64-bit signed fixed point with FRAC_BITS
// fraction bits, saturating, and goes through one 32x32 multiplier (four partial
// products per 64x64 product) and one saturating adder.
// A point near the origin finishes at the marker test, a point caught by the bulb
// test or the cardioid test finishes there, and any other point is iterated
// (three products per iteration).
// in_stall stays high from acceptance until the result is handed to the output
// register; a waiting result does not block the next point from being taken.
module mandelbrot_escape_time_unit
  import met_pkg::*;
#(
  parameter int FRAC_BITS = 28
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  met_in_t                in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output met_out_t               out_data,
  input  logic                   cfg_we,
  input  logic [LIMIT_WIDTH-1:0] cfg_data
);

  // Fixed-point constants, rounded to nearest.
  localparam logic [127:0] K245_W  = ((128'd490 << FRAC_BITS) + 128'd1000) / 128'd2000;
  localparam logic [127:0] KMARK_W = ((128'd50 << FRAC_BITS) + 128'd1000000) / 128'd2000000;
  localparam logic [127:0] KBULB_W = ((128'd12 << FRAC_BITS) + 128'd100) / 128'd200;
  localparam logic [127:0] KSKEW_W = ((128'd202 << FRAC_BITS) + 128'd100) / 128'd200;
  localparam logic signed [63:0] K_245  = K245_W[63:0];
  localparam logic signed [63:0] K_MARK = KMARK_W[63:0];
  localparam logic signed [63:0] K_BULB = KBULB_W[63:0];
  localparam logic signed [63:0] K_SKEW = KSKEW_W[63:0];
  localparam logic signed [63:0] K_ONE  = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] K_FOUR = 64'sd4 <<< FRAC_BITS;
  localparam logic signed [63:0] S_MAX  = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S_MIN  = {1'b1, {63{1'b0}}};
  localparam logic [127:0] MASK_F = (128'd1 << FRAC_BITS) - 128'd1;
  localparam logic [127:0] MASK_H = (128'd1 << (FRAC_BITS - 1)) - 128'd1;

  // Multiplier phases.
  localparam logic [2:0] MC_LOAD = 3'd0;
  localparam logic [2:0] MC_PP0  = 3'd1;
  localparam logic [2:0] MC_PP3  = 3'd4;
  localparam logic [2:0] MC_ADD3 = 3'd5;
  localparam logic [2:0] MC_FIN1 = 3'd6;
  localparam logic [2:0] MC_FIN2 = 3'd7;

  typedef enum logic [23:0] {
    S_IDLE = 24'h000001,
    S_X2   = 24'h000002,
    S_Y2   = 24'h000004,
    S_MARK = 24'h000008,
    S_XP   = 24'h000010,
    S_XP2  = 24'h000020,
    S_BULB = 24'h000040,
    S_XS   = 24'h000080,
    S_XR   = 24'h000100,
    S_XR2  = 24'h000200,
    S_Q    = 24'h000400,
    S_QX   = 24'h000800,
    S_QQ   = 24'h001000,
    S_YK   = 24'h002000,
    S_CARD = 24'h004000,
    S_ITER = 24'h008000,
    S_ZRI  = 24'h010000,
    S_ZI   = 24'h020000,
    S_DIF  = 24'h040000,
    S_ZR   = 24'h080000,
    S_ZR2  = 24'h100000,
    S_ZI2  = 24'h200000,
    S_ESC  = 24'h400000,
    S_OUT  = 24'h800000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [63:0] x_r, y_r, x2_r, y2_r, t_r, u_r, q_r, xr_r;
  logic signed [63:0] zr_r, zi_r, zr2_r, zi2_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [LIMIT_WIDTH-1:0] limit_r;
  logic [1:0]             res_cls_r;
  logic [COUNT_WIDTH-1:0] res_cnt_r;
  logic                   out_valid_r;
  met_out_t               out_data_r;

  // Shared multiplier.
  logic               mul_sel, mul_half, mul_done;
  logic signed [63:0] mul_a, mul_b, mul_res;
  logic [2:0]         mcnt_r;
  logic [63:0]        ma_r, mb_r, pp_r, pp_prod;
  logic               mneg_r, mhalf_r, over_r, sticky;
  logic [1:0]         off_r, pp_idx;
  logic [127:0]       acc_r, pp_shift, shifted;
  logic [64:0]        mag_r, mag_nxt;
  logic [31:0]        a_half, b_half;
  logic               mag_over;

  // Shared saturating adder.
  logic signed [63:0] add_a, add_b, add_res;
  logic               add_sub;
  logic [64:0]        add_ext;

  logic out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Operand routing for the multiplier.
  always_comb begin
    mul_sel  = 1'b1;
    mul_half = 1'b0;
    mul_a    = x_r;
    mul_b    = x_r;
    unique case (state_r)
      S_X2: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      S_Y2: begin
        mul_a = y_r;
        mul_b = y_r;
      end
      S_XP2: begin
        mul_a = t_r;
        mul_b = t_r;
      end
      S_XR: begin
        mul_a = t_r;
        mul_b = K_SKEW;
      end
      S_XR2: begin
        mul_a = xr_r;
        mul_b = xr_r;
      end
      S_QQ: begin
        mul_a = q_r;
        mul_b = t_r;
      end
      S_YK: begin
        mul_a = y2_r;
        mul_b = K_245;
      end
      S_ZRI: begin
        mul_a    = zr_r;
        mul_b    = zi_r;
        mul_half = 1'b1;
      end
      S_ZR2: begin
        mul_a = zr_r;
        mul_b = zr_r;
      end
      S_ZI2: begin
        mul_a = zi_r;
        mul_b = zi_r;
      end
      default: mul_sel = 1'b0;
    endcase
  end

  // Operand routing for the adder.
  always_comb begin
    add_a   = x2_r;
    add_b   = y2_r;
    add_sub = 1'b0;
    unique case (state_r)
      S_MARK: begin
        add_a = x2_r;
        add_b = y2_r;
      end
      S_XP: begin
        add_a = x_r;
        add_b = K_ONE;
      end
      S_BULB: begin
        add_a = t_r;
        add_b = y2_r;
      end
      S_XS: begin
        add_a   = x_r;
        add_b   = K_245;
        add_sub = 1'b1;
      end
      S_Q: begin
        add_a = t_r;
        add_b = y2_r;
      end
      S_QX: begin
        add_a = q_r;
        add_b = xr_r;
      end
      S_ZI: begin
        add_a = t_r;
        add_b = y_r;
      end
      S_DIF: begin
        add_a   = zr2_r;
        add_b   = zi2_r;
        add_sub = 1'b1;
      end
      S_ZR: begin
        add_a = t_r;
        add_b = x_r;
      end
      S_ESC: begin
        add_a = zr2_r;
        add_b = zi2_r;
      end
      default: begin
        add_a = x2_r;
        add_b = y2_r;
      end
    endcase
  end

  assign add_ext = add_sub ? ({add_a[63], add_a} - {add_b[63], add_b})
                           : ({add_a[63], add_a} + {add_b[63], add_b});
  assign add_res = (add_ext[64] != add_ext[63]) ? (add_ext[64] ? S_MIN : S_MAX)
                                                : add_ext[63:0];

  // Multiplier datapath: magnitudes, four partial products, shift and round.
  assign pp_idx  = 2'(mcnt_r - MC_PP0);
  assign a_half  = pp_idx[0] ? ma_r[63:32] : ma_r[31:0];
  assign b_half  = pp_idx[1] ? mb_r[63:32] : mb_r[31:0];
  assign pp_prod = a_half * b_half;

  always_comb begin
    unique case (off_r)
      2'd0:    pp_shift = {64'd0, pp_r};
      2'd1:    pp_shift = {32'd0, pp_r, 32'd0};
      2'd2:    pp_shift = {pp_r, 64'd0};
      default: pp_shift = '0;
    endcase
  end

  assign shifted = mhalf_r ? (acc_r >> (FRAC_BITS - 1)) : (acc_r >> FRAC_BITS);
  assign sticky  = mhalf_r ? ((acc_r & MASK_H) != '0) : ((acc_r & MASK_F) != '0);
  assign mag_nxt = {1'b0, shifted[63:0]} + 65'(mneg_r && sticky);

  assign mag_over = over_r || mag_r[64] || mag_r[63];
  assign mul_res  = mneg_r ? (mag_over ? S_MIN : -$signed(mag_r[63:0]))
                           : (mag_over ? S_MAX : $signed(mag_r[63:0]));
  assign mul_done = mul_sel && (mcnt_r == MC_FIN2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r <= MC_LOAD;
    end else if (mul_sel && (mcnt_r != MC_FIN2)) begin
      mcnt_r <= mcnt_r + 3'd1;
    end else begin
      mcnt_r <= MC_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_sel && (mcnt_r == MC_LOAD)) begin
      ma_r    <= mul_a[63] ? 64'(-mul_a) : 64'(mul_a);
      mb_r    <= mul_b[63] ? 64'(-mul_b) : 64'(mul_b);
      mneg_r  <= mul_a[63] ^ mul_b[63];
      mhalf_r <= mul_half;
      acc_r   <= '0;
    end
    if ((mcnt_r >= MC_PP0) && (mcnt_r <= MC_PP3)) begin
      pp_r  <= pp_prod;
      off_r <= 2'({1'b0, pp_idx[0]} + {1'b0, pp_idx[1]});
    end
    // Accumulate the partial product registered in the previous cycle.
    if ((mcnt_r > MC_PP0) && (mcnt_r <= MC_ADD3)) begin
      acc_r <= acc_r + pp_shift;
    end
    if (mcnt_r == MC_FIN1) begin
      mag_r  <= mag_nxt;
      over_r <= (shifted[127:64] != '0);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_X2;
      S_X2:   if (mul_done) state_nxt = S_Y2;
      S_Y2:   if (mul_done) state_nxt = S_MARK;
      S_MARK: state_nxt = (add_res < K_MARK) ? S_OUT : S_XP;
      S_XP:   state_nxt = S_XP2;
      S_XP2:  if (mul_done) state_nxt = S_BULB;
      S_BULB: state_nxt = (add_res < K_BULB) ? S_OUT : S_XS;
      S_XS:   state_nxt = S_XR;
      S_XR:   if (mul_done) state_nxt = S_XR2;
      S_XR2:  if (mul_done) state_nxt = S_Q;
      S_Q:    state_nxt = S_QX;
      S_QX:   state_nxt = S_QQ;
      S_QQ:   if (mul_done) state_nxt = S_YK;
      S_YK:   if (mul_done) state_nxt = S_CARD;
      S_CARD: state_nxt = (t_r < u_r) ? S_OUT : S_ITER;
      S_ITER: state_nxt = (cnt_r < limit_r) ? S_ZRI : S_OUT;
      S_ZRI:  if (mul_done) state_nxt = S_ZI;
      S_ZI:   state_nxt = S_DIF;
      S_DIF:  state_nxt = S_ZR;
      S_ZR:   state_nxt = S_ZR2;
      S_ZR2:  if (mul_done) state_nxt = S_ZI2;
      S_ZI2:  if (mul_done) state_nxt = S_ESC;
      S_ESC:  state_nxt = (add_res > K_FOUR) ? S_OUT : S_ITER;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        x_r <= 64'($signed(in_data.c_real));
        y_r <= 64'($signed(in_data.c_imag));
      end
      S_X2:   if (mul_done) x2_r <= mul_res;
      S_Y2:   if (mul_done) y2_r <= mul_res;
      S_MARK: begin
        res_cls_r <= CLS_MARKER;
        res_cnt_r <= '0;
      end
      S_XP:   t_r <= add_res;
      S_XP2:  if (mul_done) t_r <= mul_res;
      S_BULB: begin
        res_cls_r <= CLS_INSIDE;
        res_cnt_r <= COUNT_WIDTH'(limit_r);
      end
      S_XS:   t_r <= add_res;
      S_XR:   if (mul_done) xr_r <= mul_res;
      S_XR2:  if (mul_done) t_r <= mul_res;
      S_Q:    q_r <= add_res;
      S_QX:   t_r <= add_res;
      S_QQ:   if (mul_done) t_r <= mul_res;
      S_YK:   if (mul_done) u_r <= mul_res;
      S_CARD: begin
        // Start the orbit at zero.
        zr_r  <= '0;
        zi_r  <= '0;
        zr2_r <= '0;
        zi2_r <= '0;
        cnt_r <= '0;
      end
      S_ZRI:  if (mul_done) t_r <= mul_res;
      S_ZI:   zi_r <= add_res;
      S_DIF:  t_r <= add_res;
      S_ZR:   zr_r <= add_res;
      S_ZR2:  if (mul_done) zr2_r <= mul_res;
      S_ZI2:  if (mul_done) zi2_r <= mul_res;
      S_ESC: begin
        if (add_res > K_FOUR) begin
          res_cls_r <= CLS_ESCAPED;
          res_cnt_r <= cnt_r;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_data_r.point_class  <= res_cls_r;
          out_data_r.escape_count <= res_cnt_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks.
  a_mul_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
    (mcnt_r != MC_LOAD) |-> mul_sel)
    else $error("multiplier running outside a multiply step");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result presented without passing the output step");

  a_marker_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.point_class == CLS_MARKER)) |-> (out_data_r.escape_count == '0))
    else $error("marker result with nonzero count");

  a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.point_class == CLS_MARKER ||
                     out_data_r.point_class == CLS_ESCAPED ||
                     out_data_r.point_class == CLS_INSIDE))
    else $error("bad point class");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_X2))
    else $error("accepted point did not start");

endmodule

@@ verif/mandelbrot_escape_time_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for mandelbrot_escape_time_unit: classifies points in Q4.28
// with its own fixed-point escape-time model and compares every result transfer.
// Depends on met_pkg and the unit itself.
module mandelbrot_escape_time_unit_test;
  import met_pkg::*;

  localparam int FRAC = 28;
  localparam int QUIET_LIMIT = 40000;
  localparam int LONG_HOLD = 400;

  typedef logic signed [63:0] fx_t;

  localparam fx_t FX_MAX = {1'b0, {63{1'b1}}};
  localparam fx_t FX_MIN = {1'b1, 63'd0};
  localparam fx_t ONE = 64'd1 << FRAC;
  localparam fx_t FOUR = 64'd4 << FRAC;
  // decimal constants scaled by 2^FRAC, rounded half up
  localparam fx_t K_MARK = ((64'd25 << (FRAC + 1)) + 64'd1000000) / 64'd2000000;
  localparam fx_t K_BULB = ((64'd6 << (FRAC + 1)) + 64'd100) / 64'd200;
  localparam fx_t K_SHIFT = ((64'd245 << (FRAC + 1)) + 64'd1000) / 64'd2000;
  localparam fx_t K_SKEW = ((64'd101 << (FRAC + 1)) + 64'd100) / 64'd200;

  typedef struct {
    met_in_t pt;
    bit      drain;
  } pending_point_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  met_in_t                in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  met_out_t               out_data;
  logic                   cfg_we = 1'b0;
  logic [LIMIT_WIDTH-1:0] cfg_data = '0;

  pending_point_t         point_q[$];
  met_out_t               escape_result_q[$];
  logic [LIMIT_WIDTH-1:0] iter_limit = LIMIT_RESET;
  int                     send_idle_pct = 0;
  int                     recv_idle_pct = 0;
  bit                     hold_req = 1'b0;
  int                     hold_left = 0;
  int                     mismatches = 0;
  int                     quiet_cycles = 0;

  mandelbrot_escape_time_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Fixed-point escape-time model: 64-bit signed, saturating.

  function automatic fx_t fx_add(fx_t a, fx_t b);
    logic signed [64:0] sum;
    sum = a + b;
    if (sum > FX_MAX) return FX_MAX;
    if (sum < FX_MIN) return FX_MIN;
    return fx_t'(sum);
  endfunction

  function automatic fx_t fx_sub(fx_t a, fx_t b);
    logic signed [64:0] diff;
    diff = a - b;
    if (diff > FX_MAX) return FX_MAX;
    if (diff < FX_MIN) return FX_MIN;
    return fx_t'(diff);
  endfunction

  // exact product, arithmetic shift right (floor), saturate
  function automatic fx_t fx_mul(fx_t a, fx_t b, int shift);
    logic signed [127:0] prod;
    prod = a * b;
    prod = prod >>> shift;
    if (prod > FX_MAX) return FX_MAX;
    if (prod < FX_MIN) return FX_MIN;
    return fx_t'(prod);
  endfunction

  function automatic met_out_t classify_point(met_in_t pt, logic [LIMIT_WIDTH-1:0] limit);
    met_out_t res;
    fx_t x, y, x2, y2, xp, xr, q;
    fx_t zr, zi, zr2, zi2;
    bit in_set;
    x = pt.c_real;
    y = pt.c_imag;
    x2 = fx_mul(x, x, FRAC);
    y2 = fx_mul(y, y, FRAC);
    if (fx_add(x2, y2) < K_MARK) begin
      res.point_class = CLS_MARKER;
      res.escape_count = '0;
      return res;
    end
    xp = fx_add(x, ONE);
    in_set = fx_add(fx_mul(xp, xp, FRAC), y2) < K_BULB;
    if (!in_set) begin
      xr = fx_mul(fx_sub(x, K_SHIFT), K_SKEW, FRAC);
      q = fx_add(fx_mul(xr, xr, FRAC), y2);
      in_set = fx_mul(q, fx_add(q, xr), FRAC) < fx_mul(y2, K_SHIFT, FRAC);
    end
    res.point_class = CLS_INSIDE;
    res.escape_count = COUNT_WIDTH'(limit);
    if (!in_set) begin
      zr = '0;
      zi = '0;
      zr2 = '0;
      zi2 = '0;
      for (int n = 0; n < limit; n++) begin
        zi = fx_add(fx_mul(zr, zi, FRAC - 1), y);
        zr = fx_add(fx_sub(zr2, zi2), x);
        zr2 = fx_mul(zr, zr, FRAC);
        zi2 = fx_mul(zi, zi, FRAC);
        if (fx_add(zr2, zi2) > FOUR) begin
          res.point_class = CLS_ESCAPED;
          res.escape_count = COUNT_WIDTH'(n);
          break;
        end
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Point construction

  function automatic int to_q(real r);
    return $rtoi(r * 268435456.0);
  endfunction

  function automatic met_in_t make_point(real re, real im);
    met_in_t p;
    p.c_real = to_q(re);
    p.c_imag = to_q(im);
    return p;
  endfunction

  function automatic met_in_t raw_point(logic [31:0] re, logic [31:0] im);
    met_in_t p;
    p.c_real = re;
    p.c_imag = im;
    return p;
  endfunction

  // mostly the interesting window around the set, plus origin, bulb and raw noise
  function automatic met_in_t random_point();
    met_in_t p;
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) begin
      p.c_real = $urandom;
      p.c_imag = $urandom;
    end else if (sel < 22) begin
      p.c_real = $urandom_range(0, 4000000) - 2000000;
      p.c_imag = $urandom_range(0, 4000000) - 2000000;
    end else if (sel < 35) begin
      p.c_real = to_q(-1.35) + $urandom_range(0, to_q(0.7));
      p.c_imag = to_q(-0.35) + $urandom_range(0, to_q(0.7));
    end else begin
      p.c_real = to_q(-2.2) + $urandom_range(0, to_q(3.0));
      p.c_imag = to_q(-1.3) + $urandom_range(0, to_q(2.6));
    end
    return p;
  endfunction

  task automatic queue_point(met_in_t p, bit drain = 1'b0);
    pending_point_t item;
    item.pt = p;
    item.drain = drain;
    point_q.push_back(item);
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) queue_point(random_point());
  endtask

  // sample away from the rising edge so driver updates have settled
  task automatic wait_drained();
    while (point_q.size() != 0 || escape_result_q.size() != 0 || in_valid)
      @(negedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_WIDTH-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    iter_limit = value;
  endtask

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: predict on transfer, hold while stalled, else offer next point unless idling or waiting to drain

  always @(posedge clk) begin
    pending_point_t next_item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) escape_result_q.push_back(classify_point(in_data, iter_limit));
      if (in_valid && in_stall) begin
        // hold the stalled payload
      end else if (point_q.size() != 0
                   && !(point_q[0].drain && escape_result_q.size() != 0)
                   && $urandom_range(99) >= send_idle_pct) begin
        next_item = point_q.pop_front();
        in_valid <= 1'b1;
        in_data <= next_item.pt;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk) begin
    met_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (escape_result_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result class %0d count %0d",
                                  out_data.point_class, out_data.escape_count));
        end else begin
          want = escape_result_q.pop_front();
          if (out_data.point_class !== want.point_class)
            note_mismatch($sformatf("point_class expected %0d got %0d",
                                    want.point_class, out_data.point_class));
          if (out_data.escape_count !== want.escape_count)
            note_mismatch($sformatf("escape_count expected %0d got %0d",
                                    want.escape_count, out_data.escape_count));
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL mandelbrot_escape_time_unit");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 33;
    recv_idle_pct = 77;

    // reset limit: markers, bulb, cardioid, quick escapes, saturating corners
    queue_point(make_point(0.0, 0.0));
    queue_point(make_point(0.0049, 0.0));
    queue_point(make_point(0.0036, -0.0036));
    queue_point(make_point(0.0051, 0.0));
    queue_point(make_point(-1.0, 0.0));
    queue_point(make_point(-1.2, 0.1));
    queue_point(make_point(0.1, 0.1));
    queue_point(make_point(0.3, 0.0));
    queue_point(make_point(-0.75, 0.1));
    queue_point(make_point(-2.1, 0.0));
    queue_point(make_point(0.5, 0.5));
    queue_point(raw_point(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    queue_point(raw_point(32'h8000_0000, 32'h8000_0000));
    queue_point(raw_point(32'h7FFF_FFFF, 32'h8000_0000));
    queue_point(raw_point(32'h0000_0000, 32'h8000_0000));

    // zero limit: nothing iterates
    write_limit('0);
    queue_point(make_point(0.5, 0.5));
    queue_point(make_point(0.0, 0.0));
    queue_point(raw_point(32'h8000_0000, 32'h0000_0000));

    write_limit(16'd1);
    queue_point(make_point(0.5, 0.5));
    queue_point(make_point(3.0, 0.0));
    queue_point(make_point(-1.0, 0.0));

    // top limit: only points that finish fast
    write_limit(16'hFFFF);
    queue_point(make_point(0.1, 0.1));
    queue_point(make_point(-0.9, -0.1));
    queue_point(raw_point(32'h7FFF_FFFF, 32'h0000_0000));
    queue_point(make_point(0.3, 0.0));
    queue_point(make_point(0.001, 0.002));

    write_limit(16'($urandom_range(2, 24)));
    queue_random(32);

    write_limit(16'($urandom_range(25, 160)));
    send_idle_pct = 77;
    recv_idle_pct = 33;
    queue_random(32);

    // no idling; long receiver hold-off to back up the unit, then a full drain
    write_limit(16'($urandom_range(8, 64)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    queue_random(15);
    queue_point(random_point(), 1'b1);
    queue_random(16);

    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0)
      $display("PASS mandelbrot_escape_time_unit");
    else
      $display("FAIL mandelbrot_escape_time_unit");
    $finish;
  end

endmodule

@@ sim.f @@
design/met_pkg.sv
design/mandelbrot_escape_time_unit.sv
verif/mandelbrot_escape_time_unit_test.sv
